// ----- sv/cbf_pkg.sv -----
// Shared types and constants of the cubic Bezier flattener.
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

    // Fixed field widths
    localparam int LVL_W      = 3;    // subdivision level, 0..6
    localparam int CFG_W      = 3;    // depth_limit register
    localparam int TOL_W      = 31;   // tolerance, unsigned Q15.16
    localparam int TOL_SQ_W   = 2 * TOL_W;
    localparam int TOL_SHIFT  = 6;    // 64 * tol^2 on the right side of the test
    localparam int DEPTH_CAP  = 6;    // at most 64 points per curve
    localparam int NUM_COORD  = 8;    // p0x p0y p1x p1y p2x p2y p3x p3y

    localparam logic [CFG_W-1:0] DEPTH_LIMIT_RESET = CFG_W'(6);

    // Defaults of the top level parameters
    localparam int MAX_DEPTH_DEF   = 6;
    localparam int COORD_WIDTH_DEF = 32;

    // Coordinate slots within a curve
    localparam int P0X = 0;
    localparam int P0Y = 1;
    localparam int P1X = 2;
    localparam int P1Y = 3;
    localparam int P2X = 4;
    localparam int P2Y = 5;
    localparam int P3X = 6;
    localparam int P3Y = 7;

    // Walk sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_WAIT,
        ST_SPLIT,
        ST_EMIT,
        ST_POP
    } cbf_state_t;

    // Flatness unit phases
    typedef enum logic [1:0] {
        FT_IDLE,
        FT_MAG,
        FT_MUL,
        FT_CMP
    } ft_phase_t;

    // Flatness unit result
    typedef struct packed {
        logic done;
        logic flat;
    } flat_res_t;

endpackage

`default_nettype wire

// ----- sv/cubic_bezier_flattener.sv -----
// Top level: adaptive cubic Bezier flattener with a RAM stack of pending right halves.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | start_x/y ctrl1_x/y ctrl2_x/y end_x/y tolerance
//  out     | out_valid/out_ready | point_x point_y last_point
//  cfg     | cfg_write           | cfg_data (depth_limit)
//
// One curve is worked at a time. A split piece passes test issue, the flatness unit
// and the split; a tested flat piece passes test issue, the flatness unit and emit;
// a piece at the depth limit goes from test issue straight to emit. The flatness unit
// squares the midpoint offset as three passes of one half-width multiplier pair.
// Reset clears the sequencer, stack pointer, output valid and sets depth_limit to 6;
// the stack RAM is not cleared and is only read where it was written for this curve.
// A stalled output holds the walk in the emit state; the next item is taken as soon
// as the last point sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_flattener #(
    parameter int MAX_DEPTH   = cbf_pkg::MAX_DEPTH_DEF,
    parameter int COORD_WIDTH = cbf_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl1_x,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl1_y,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl2_x,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl2_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    input  wire logic [cbf_pkg::TOL_W-1:0]     tolerance,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y,
    output logic                               last_point,

    input  wire logic                          cfg_write,
    input  wire logic [cbf_pkg::CFG_W-1:0]     cfg_data
);

    import cbf_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int AW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SPW    = $clog2(MAX_DEPTH + 1);
    localparam int RAM_W  = NUM_COORD * W + LVL_W;
    localparam logic [LVL_W-1:0] LIMIT_CAP =
        LVL_W'((MAX_DEPTH < DEPTH_CAP) ? MAX_DEPTH : DEPTH_CAP);

    // Sequencer and walk state
    cbf_state_t              state_reg, state_next;
    logic [LVL_W-1:0]        level_reg, level_next;
    logic [SPW-1:0]          sp_reg, sp_next;
    logic [CFG_W-1:0]        limit_reg, limit_next;
    logic signed [W-1:0]     curve_reg [NUM_COORD];
    logic signed [W-1:0]     curve_next [NUM_COORD];
    logic [TOL_SQ_W-1:0]     tol_sq_reg, tol_sq_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [W-1:0]     point_x_reg, point_x_next, point_y_reg, point_y_next;
    logic                    last_reg, last_next;

    // Control
    logic                    accept, emit_fire, flat_start, ram_we;
    logic [AW-1:0]           ram_addr;
    logic [RAM_W-1:0]        ram_wr_data, ram_rd_data;
    logic [LVL_W-1:0]        eff_limit;
    flat_res_t               flat_res;

    // de Casteljau halves
    logic signed [W-1:0]     left_c [NUM_COORD];
    logic signed [W-1:0]     right_c [NUM_COORD];
    logic signed [W-1:0]     ab [2];
    logic signed [W-1:0]     bc [2];
    logic signed [W-1:0]     cd [2];
    logic signed [W-1:0]     abc [2];
    logic signed [W-1:0]     bcd [2];
    logic signed [W-1:0]     mid [2];

    // floor((a + b) / 2), stays inside the coordinate range
    function automatic logic signed [W-1:0] half_sum(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return s[W:1];
    endfunction

    // Smallest of depth_limit, MAX_DEPTH and 6
    assign eff_limit = (LVL_W'(limit_reg) > LIMIT_CAP) ? LIMIT_CAP : LVL_W'(limit_reg);

    // Stack of right halves with their levels
    cbf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .we      (ram_we),
        .addr    (ram_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    cbf_flat_test #(
        .COORD_WIDTH (W)
    ) u_flat (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (flat_start),
        .curve  (curve_reg),
        .tol_sq (tol_sq_reg),
        .res    (flat_res)
    );

    // Split the current piece, both axes side by side
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            ab[a]  = half_sum(curve_reg[P0X + a], curve_reg[P1X + a]);
            bc[a]  = half_sum(curve_reg[P1X + a], curve_reg[P2X + a]);
            cd[a]  = half_sum(curve_reg[P2X + a], curve_reg[P3X + a]);
            abc[a] = half_sum(ab[a], bc[a]);
            bcd[a] = half_sum(bc[a], cd[a]);
            mid[a] = half_sum(abc[a], bcd[a]);
            left_c[P0X + a]  = curve_reg[P0X + a];
            left_c[P1X + a]  = ab[a];
            left_c[P2X + a]  = abc[a];
            left_c[P3X + a]  = mid[a];
            right_c[P0X + a] = mid[a];
            right_c[P1X + a] = bcd[a];
            right_c[P2X + a] = cd[a];
            right_c[P3X + a] = curve_reg[P3X + a];
        end
    end

    // Stack entry layout: coordinates low, level on top
    always_comb
    begin
        for (int i = 0; i < NUM_COORD; i++)
        begin
            ram_wr_data[i*W +: W] = right_c[i];
        end
        ram_wr_data[NUM_COORD*W +: LVL_W] = level_reg + LVL_W'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid) state_next = ST_TEST;
            ST_TEST:
                // at the limit the piece goes out untested
                state_next = (level_reg >= eff_limit) ? ST_EMIT : ST_WAIT;
            ST_WAIT:
                if (flat_res.done) state_next = flat_res.flat ? ST_EMIT : ST_SPLIT;
            ST_SPLIT:
                state_next = ST_TEST;
            ST_EMIT:
                if (emit_fire) state_next = (sp_reg == '0) ? ST_IDLE : ST_POP;
            ST_POP:
                state_next = ST_TEST;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        accept     = in_ready && in_valid;
        flat_start = (state_reg == ST_TEST) && (level_reg < eff_limit);
        emit_fire  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        ram_we     = (state_reg == ST_SPLIT);
        // push at sp, pop reads sp - 1 while emitting
        ram_addr   = ram_we ? sp_reg[AW-1:0] : AW'(sp_reg - SPW'(1));
    end

    // Walk state and output register
    always_comb
    begin
        level_next     = level_reg;
        sp_next        = sp_reg;
        curve_next     = curve_reg;
        tol_sq_next    = tol_sq_reg;
        limit_next     = cfg_write ? cfg_data : limit_reg;
        point_x_next   = point_x_reg;
        point_y_next   = point_y_reg;
        last_next      = last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    curve_next[P0X] = start_x;
                    curve_next[P0Y] = start_y;
                    curve_next[P1X] = ctrl1_x;
                    curve_next[P1Y] = ctrl1_y;
                    curve_next[P2X] = ctrl2_x;
                    curve_next[P2Y] = ctrl2_y;
                    curve_next[P3X] = end_x;
                    curve_next[P3Y] = end_y;
                    tol_sq_next     = tolerance * tolerance;
                    level_next      = '0;
                    sp_next         = '0;
                end
            ST_SPLIT:
            begin
                curve_next = left_c;
                level_next = level_reg + LVL_W'(1);
                sp_next    = sp_reg + SPW'(1);
            end
            ST_EMIT:
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    point_x_next   = curve_reg[P3X];
                    point_y_next   = curve_reg[P3Y];
                    last_next      = (sp_reg == '0);
                    if (sp_reg != '0)
                    begin
                        sp_next = sp_reg - SPW'(1);
                    end
                end
            ST_POP:
            begin
                for (int i = 0; i < NUM_COORD; i++)
                begin
                    curve_next[i] = ram_rd_data[i*W +: W];
                end
                level_next = ram_rd_data[NUM_COORD*W +: LVL_W];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            sp_reg        <= '0;
            limit_reg     <= DEPTH_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            sp_reg        <= sp_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        curve_reg   <= curve_next;
        tol_sq_reg  <= tol_sq_next;
        point_x_reg <= point_x_next;
        point_y_reg <= point_y_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign last_point = last_reg;

    // Checks

    // a push never runs past the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT) |-> (sp_reg < SPW'(MAX_DEPTH)))
        else $error("stack push beyond depth");

    // the final point closes the curve and frees the input at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (sp_reg == '0)) |=> (out_valid && last_point && in_ready))
        else $error("last point not followed by idle");

    // flatness results only arrive while the walk waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        flat_res.done |-> (state_reg == ST_WAIT))
        else $error("stray flatness result");

    // a piece under test never lies deeper than the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> (level_reg <= eff_limit))
        else $error("level beyond depth limit");

endmodule

`default_nettype wire

// ----- sv/cbf_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/cbf_flat_test.sv -----
// Flatness test: squared midpoint offset against 64 * tol^2 on one shared multiplier pair.
`timescale 1ns / 1ps
`default_nettype none

module cbf_flat_test #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [COORD_WIDTH-1:0] curve [8],
    input  wire logic [cbf_pkg::TOL_SQ_W-1:0]  tol_sq,
    output cbf_pkg::flat_res_t                 res
);

    import cbf_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int EW     = W + 4;              // signed 3*(c1 + c2 - p0 - p3)
    localparam int MW     = W + 3;              // its magnitude
    localparam int HW     = (MW + 1) / 2;       // half of the magnitude
    localparam int PW     = 2 * HW;             // one partial product
    localparam int RHS_W  = TOL_SQ_W + TOL_SHIFT;
    localparam int SQ_W   = 2 * MW + 1;
    localparam int ACC_W  = (SQ_W > RHS_W) ? SQ_W : RHS_W;
    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] STEP_LL = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_HL = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_HH = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_END = STEP_W'(3);

    ft_phase_t               phase_reg, phase_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [EW-1:0]    sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [PW-1:0]           mx_reg, mx_next, my_reg, my_next;
    logic [PW-1:0]           px_reg, px_next, py_reg, py_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;

    logic signed [EW-1:0]    e3_x, e3_y, abs_x, abs_y;
    logic [HW-1:0]           op_ax, op_bx, op_ay, op_by;
    logic [PW:0]             psum;
    logic [ACC_W-1:0]        term, rhs;

    function automatic logic signed [EW-1:0] sx(input logic signed [W-1:0] v);
        return {{(EW-W){v[W-1]}}, v};
    endfunction

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            FT_IDLE: if (start) phase_next = FT_MAG;
            FT_MAG:  phase_next = FT_MUL;
            FT_MUL:  if (step_reg == STEP_END) phase_next = FT_CMP;
            FT_CMP:  phase_next = FT_IDLE;
            default: phase_next = FT_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        rhs      = ACC_W'({tol_sq, {TOL_SHIFT{1'b0}}});
        res.done = (phase_reg == FT_CMP);
        res.flat = (acc_reg <= rhs);
    end

    // Datapath
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;

        e3_x  = sum_x_reg + (sum_x_reg <<< 1);
        e3_y  = sum_y_reg + (sum_y_reg <<< 1);
        abs_x = e3_x[EW-1] ? -e3_x : e3_x;
        abs_y = e3_y[EW-1] ? -e3_y : e3_y;

        // operand pairs: lo*lo, hi*lo (counted twice), hi*hi
        case (step_reg)
            STEP_LL:
            begin
                op_ax = mx_reg[HW-1:0];
                op_bx = mx_reg[HW-1:0];
                op_ay = my_reg[HW-1:0];
                op_by = my_reg[HW-1:0];
            end
            STEP_HL:
            begin
                op_ax = mx_reg[PW-1:HW];
                op_bx = mx_reg[HW-1:0];
                op_ay = my_reg[PW-1:HW];
                op_by = my_reg[HW-1:0];
            end
            default:
            begin
                op_ax = mx_reg[PW-1:HW];
                op_bx = mx_reg[PW-1:HW];
                op_ay = my_reg[PW-1:HW];
                op_by = my_reg[PW-1:HW];
            end
        endcase
        px_next = op_ax * op_bx;
        py_next = op_ay * op_by;

        // product registered last cycle belongs to step_reg - 1
        psum = {1'b0, px_reg} + {1'b0, py_reg};
        case (step_reg)
            STEP_HL: term = ACC_W'(psum);
            STEP_HH: term = ACC_W'(psum) << (HW + 1);
            default: term = ACC_W'(psum) << (2 * HW);
        endcase

        case (phase_reg)
            FT_IDLE:
            begin
                sum_x_next = sx(curve[P1X]) + sx(curve[P2X]) - sx(curve[P0X]) - sx(curve[P3X]);
                sum_y_next = sx(curve[P1Y]) + sx(curve[P2Y]) - sx(curve[P0Y]) - sx(curve[P3Y]);
            end
            FT_MAG:
            begin
                mx_next   = PW'(abs_x[MW-1:0]);
                my_next   = PW'(abs_y[MW-1:0]);
                acc_next  = '0;
                step_next = STEP_LL;
            end
            FT_MUL:
            begin
                if (step_reg != STEP_LL)
                begin
                    acc_next = acc_reg + term;
                end
                step_next = step_reg + STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FT_IDLE;
            step_reg  <= STEP_LL;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_x_reg <= sum_x_next;
        sum_y_reg <= sum_y_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        acc_reg   <= acc_next;
    end

endmodule

`default_nettype wire

// ----- test/cbf_point_checker.sv -----
// Checker for the cubic Bezier flattener: predicts the point stream of each curve and compares.
`timescale 1ns / 1ps

module cbf_point_checker #(
    parameter int MAX_DEPTH   = cbf_pkg::MAX_DEPTH_DEF,
    parameter int COORD_WIDTH = cbf_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl1_x,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl1_y,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl2_x,
    input  wire logic signed [COORD_WIDTH-1:0] ctrl2_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    input  wire logic [cbf_pkg::TOL_W-1:0]     tolerance,

    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic                          last_point,

    input  wire logic                          cfg_write,
    input  wire logic [cbf_pkg::CFG_W-1:0]     cfg_data,

    output int                                 mismatches,
    output int                                 points_waiting,
    output int                                 curves_taken,
    output int                                 points_checked
);

    import cbf_pkg::*;

    localparam int MAX_POINTS = 1 << DEPTH_CAP;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          last;
    } curve_point_t;

    curve_point_t     expected_points [$];
    logic [CFG_W-1:0] depth_setting = DEPTH_LIMIT_RESET;
    int               n_fail = 0;
    int               n_curves = 0;
    int               n_points = 0;

    // exact test: (3*(c1 + c2 - p0 - p3))^2 summed over both axes <= 64 * tol^2
    function automatic bit piece_is_flat(input longint c [8], input logic [TOL_W-1:0] tol);
        longint       ex;
        longint       ey;
        logic [63:0]  mag_x;
        logic [63:0]  mag_y;
        logic [127:0] deviation;
        logic [127:0] bound;
        ex = 3 * (c[P1X] + c[P2X] - c[P0X] - c[P3X]);
        ey = 3 * (c[P1Y] + c[P2Y] - c[P0Y] - c[P3Y]);
        mag_x = (ex < 0) ? -ex : ex;
        mag_y = (ey < 0) ? -ey : ey;
        deviation = {64'd0, mag_x} * {64'd0, mag_x} + {64'd0, mag_y} * {64'd0, mag_y};
        bound = ({97'd0, tol} * {97'd0, tol}) << TOL_SHIFT;
        return deviation <= bound;
    endfunction

    // depth-first de Casteljau walk; right halves wait on a local stack
    function automatic void flatten_curve(input longint curve_in [8],
                                          input logic [TOL_W-1:0] tol, input int limit);
        longint       cur [8];
        longint       left [8];
        longint       right [8];
        longint       halves [MAX_DEPTH][8];
        int           levels [MAX_DEPTH];
        int           sp;
        int           lvl;
        int           n;
        bit           busy;
        bit           last;
        longint       ab;
        longint       bc;
        longint       cd;
        longint       abc;
        longint       bcd;
        longint       mid;
        curve_point_t pt;
        cur = curve_in;
        sp = 0;
        lvl = 0;
        n = 0;
        busy = 1'b1;
        while (busy)
        begin
            if (lvl >= limit || piece_is_flat(cur, tol))
            begin
                last = (sp == 0);
                pt.x = COORD_WIDTH'(cur[P3X]);
                pt.y = COORD_WIDTH'(cur[P3Y]);
                pt.last = last;
                expected_points.push_back(pt);
                n++;
                if (last || n >= MAX_POINTS)
                    busy = 1'b0;
                else
                begin
                    sp--;
                    cur = halves[sp];
                    lvl = levels[sp];
                end
            end
            else
            begin
                // midpoints floor-halved (arithmetic shift)
                for (int a = 0; a < 2; a++)
                begin
                    ab  = (cur[P0X + a] + cur[P1X + a]) >>> 1;
                    bc  = (cur[P1X + a] + cur[P2X + a]) >>> 1;
                    cd  = (cur[P2X + a] + cur[P3X + a]) >>> 1;
                    abc = (ab + bc) >>> 1;
                    bcd = (bc + cd) >>> 1;
                    mid = (abc + bcd) >>> 1;
                    left[P0X + a]  = cur[P0X + a];
                    left[P1X + a]  = ab;
                    left[P2X + a]  = abc;
                    left[P3X + a]  = mid;
                    right[P0X + a] = mid;
                    right[P1X + a] = bcd;
                    right[P2X + a] = cd;
                    right[P3X + a] = cur[P3X + a];
                end
                if (sp >= MAX_DEPTH)
                    busy = 1'b0;
                else
                begin
                    halves[sp] = right;
                    levels[sp] = lvl + 1;
                    sp++;
                    cur = left;
                    lvl++;
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        curve_point_t want;
        longint       pts [8];
        int           eff_limit;
        if (!rst_n)
        begin
            expected_points.delete();
            depth_setting = DEPTH_LIMIT_RESET;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_points++;
                if (expected_points.size() == 0)
                begin
                    $error("unexpected point: x %0d y %0d last %0b",
                           point_x, point_y, last_point);
                    n_fail++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (point_x !== want.x)
                    begin
                        $error("point_x: expected %0d, got %0d", want.x, point_x);
                        n_fail++;
                    end
                    if (point_y !== want.y)
                    begin
                        $error("point_y: expected %0d, got %0d", want.y, point_y);
                        n_fail++;
                    end
                    if (last_point !== want.last)
                    begin
                        $error("last_point: expected %0b, got %0b", want.last, last_point);
                        n_fail++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pts[P0X] = start_x;
                pts[P0Y] = start_y;
                pts[P1X] = ctrl1_x;
                pts[P1Y] = ctrl1_y;
                pts[P2X] = ctrl2_x;
                pts[P2Y] = ctrl2_y;
                pts[P3X] = end_x;
                pts[P3Y] = end_y;
                eff_limit = depth_setting;
                if (eff_limit > MAX_DEPTH)
                    eff_limit = MAX_DEPTH;
                if (eff_limit > DEPTH_CAP)
                    eff_limit = DEPTH_CAP;
                flatten_curve(pts, tolerance, eff_limit);
                n_curves++;
            end
            if (cfg_write)
                depth_setting = cfg_data;
        end
        mismatches     <= n_fail;
        points_waiting <= expected_points.size();
        curves_taken   <= n_curves;
        points_checked <= n_points;
    end

endmodule

// ----- test/tb_cubic_bezier_flattener.sv -----
// Testbench top for the cubic Bezier flattener: clock, reset, curve stimulus and verdict.
`timescale 1ns / 1ps

module tb_cubic_bezier_flattener;

    import cbf_pkg::*;

    localparam int CW               = COORD_WIDTH_DEF;
    localparam int RESET_CYCLES     = 3;
    localparam int SETTLE_CYCLES    = 32;    // block is idle once its last point is taken
    localparam int QUIET_LIMIT      = 4000;  // cycles with no item moving on either side
    localparam int NUM_PHASES       = 8;
    localparam int CURVES_PER_PHASE = 27;

    localparam logic signed [CW-1:0]    C_MIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0]    C_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [TOL_W-1:0]        TOL_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [CW-1:0] start_x = '0;
    logic signed [CW-1:0] start_y = '0;
    logic signed [CW-1:0] ctrl1_x = '0;
    logic signed [CW-1:0] ctrl1_y = '0;
    logic signed [CW-1:0] ctrl2_x = '0;
    logic signed [CW-1:0] ctrl2_y = '0;
    logic signed [CW-1:0] end_x = '0;
    logic signed [CW-1:0] end_y = '0;
    logic [TOL_W-1:0]     tolerance = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 last_point;

    logic                 cfg_write = 1'b0;
    logic [CFG_W-1:0]     cfg_data = DEPTH_LIMIT_RESET;

    int                   mismatches;
    int                   points_waiting;
    int                   curves_taken;
    int                   points_checked;

    // curve staged for the next send
    logic signed [CW-1:0] shape [8];
    logic [TOL_W-1:0]     shape_tol;
    int                   burst_left = 0;
    int                   ready_left = 0;
    int                   quiet_cycles = 0;

    always #6 clk = ~clk;

    cubic_bezier_flattener dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .ctrl1_x    (ctrl1_x),
        .ctrl1_y    (ctrl1_y),
        .ctrl2_x    (ctrl2_x),
        .ctrl2_y    (ctrl2_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .tolerance  (tolerance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data)
    );

    // Watches both channels and the config port, predicts every point and compares.
    cbf_point_checker point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_x        (start_x),
        .start_y        (start_y),
        .ctrl1_x        (ctrl1_x),
        .ctrl1_y        (ctrl1_y),
        .ctrl2_x        (ctrl2_x),
        .ctrl2_y        (ctrl2_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .tolerance      (tolerance),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .last_point     (last_point),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .points_waiting (points_waiting),
        .curves_taken   (curves_taken),
        .points_checked (points_checked)
    );

    // Point receiver: open stretches, hard stalls, and choppy cycle-by-cycle ready.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    out_ready  <= 1'b1;
                    ready_left <= $urandom_range(10, 60);
                end
                1:
                begin
                    out_ready  <= 1'b0;
                    ready_left <= $urandom_range(1, 16);
                end
                default:
                begin
                    out_ready  <= 1'($urandom_range(0, 1));
                    ready_left <= 0;
                end
            endcase
        end
    end

    // Watchdog: a hung walk or a lost handshake stops the run here.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present the staged curve and hold it until taken. Valid stays up inside a
    // burst; at the end of a burst it drops for a random gap.
    task automatic send_curve();
        in_valid  <= 1'b1;
        start_x   <= shape[P0X];
        start_y   <= shape[P0Y];
        ctrl1_x   <= shape[P1X];
        ctrl1_y   <= shape[P1Y];
        ctrl2_x   <= shape[P2X];
        ctrl2_y   <= shape[P2Y];
        end_x     <= shape[P3X];
        end_y     <= shape[P3Y];
        tolerance <= shape_tol;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    task automatic load_shape(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                              input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                              input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                              input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
                              input logic [TOL_W-1:0] tol);
        shape[P0X] = sx;
        shape[P0Y] = sy;
        shape[P1X] = ax;
        shape[P1Y] = ay;
        shape[P2X] = bx;
        shape[P2Y] = by;
        shape[P3X] = ex;
        shape[P3Y] = ey;
        shape_tol  = tol;
        send_curve();
    endtask

    // Stop sending and wait until every predicted point has been taken.
    task automatic drain_points();
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random curve. Most are bounded curves around a random origin whose tolerance
    // scales with the curve size, so the walk stops at every level; some have zero-offset
    // controls or extreme tolerances, the rest are full-range noise and corner values.
    task automatic make_random_curve();
        int                   kind;
        int                   span;
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        kind = $urandom_range(0, 9);
        if (kind == 6)
        begin
            for (int k = 0; k < NUM_COORD; k++)
                shape[k] = $urandom();
            shape_tol = TOL_W'($urandom());
        end
        else if (kind == 7)
        begin
            for (int k = 0; k < NUM_COORD; k++)
            begin
                case ($urandom_range(0, 4))
                    0: shape[k] = C_MIN;
                    1: shape[k] = C_MAX;
                    2: shape[k] = '0;
                    3: shape[k] = -1;
                    default: shape[k] = 1;
                endcase
            end
            case ($urandom_range(0, 3))
                0: shape_tol = '0;
                1: shape_tol = TOL_MAX;
                2: shape_tol = TOL_W'(1);
                default: shape_tol = TOL_W'($urandom());
            endcase
        end
        else
        begin
            span   = 1 << $urandom_range(4, 28);
            base_x = $signed($urandom()) >>> 1;
            base_y = $signed($urandom()) >>> 1;
            for (int k = 0; k < NUM_COORD; k++)
                shape[k] = ((k % 2) ? base_y : base_x)
                           + int'($urandom_range(0, 2 * span)) - span;
            shape_tol = TOL_W'($urandom_range(0, span) >> $urandom_range(0, 10));
            if (kind == 5)
            begin
                // controls symmetric about the chord: midpoint offset exactly zero
                shape[P2X] = shape[P0X] + shape[P3X] - shape[P1X];
                shape[P2Y] = shape[P0Y] + shape[P3Y] - shape[P1Y];
                if ($urandom_range(0, 1))
                    shape_tol = '0;
            end
            else if (kind == 8)
                shape_tol = $urandom_range(0, 1) ? TOL_MAX : '0;
            else if (kind == 9)
                shape_tol = TOL_W'($urandom_range(0, 3));
        end
    endtask

    function automatic logic [CFG_W-1:0] depth_for_phase(input int p);
        case (p)
            0:       return 3'd0;   // whole curve is one piece
            1:       return 3'd7;   // above the parameter, clamps to 6
            2:       return 3'd3;
            3:       return 3'd1;
            4:       return 3'd6;
            5:       return 3'd5;
            6:       return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed curves under the reset depth limit
        load_shape('0, '0, '0, '0, '0, '0, '0, '0, '0);              // all zero, zero tol
        load_shape(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, '0);
        load_shape(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, TOL_MAX);
        // widest hump, zero tolerance: runs to the depth limit, 64 points
        load_shape(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, '0);
        load_shape(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, TOL_MAX);
        load_shape(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, '0);
        load_shape(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, '0);
        // straight line with zero tolerance: exactly flat at once
        load_shape(-32'sd65536, 32'sd65536, 32'sd0, 32'sd131072,
                   32'sd65536, 32'sd196608, 32'sd131072, 32'sd262144, '0);
        // slightly bent, zero tolerance: the whole curve is not flat
        load_shape(32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd6, 32'sd1, 32'sd9, 32'sd0, '0);
        // odd sums around zero exercise rounding toward minus infinity
        load_shape(-1, 1, 1, -1, 1, -1, -1, 1, '0);
        load_shape(-1, 1, 1, -1, 1, -1, -1, 1, TOL_W'(1));
        load_shape(32'sd0, 32'sd0, 32'sd65536, 32'sd655360,
                   32'sd589824, 32'sd655360, 32'sd655360, 32'sd0, 31'd16384);
        load_shape(32'sd12345, -32'sd777, 32'sd12345, -32'sd777,
                   32'sd12345, -32'sd777, 32'sd12345, -32'sd777, '0);

        // sender holds off until every point has come back
        drain_points();

        // One phase per depth setting; each opens with the widest hump
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_depth(depth_for_phase(p));
            load_shape(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, '0);
            for (int i = 0; i < CURVES_PER_PHASE; i++)
            begin
                make_random_curve();
                send_curve();
                if ($urandom_range(0, 19) == 0)
                    drain_points();
            end
            drain_points();
        end

        $display("Run covered %0d curves and %0d points, depth limits 0 to 7,",
                 curves_taken, points_checked);
        $display("with line, corner, full-range and tolerance-extreme curves under stalls.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
